### src/gpp_pkg.sv
// Shared types, constants and reciprocal tables for the GBM price path step block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gpp_pkg;

  localparam int unsigned MAX_STEPS  = 1024;
  localparam int unsigned PRICE_W    = 40;
  localparam int unsigned UNI_W      = 32;
  localparam int unsigned STEP_W     = 11;
  localparam int unsigned PATH_W     = 16;
  localparam int unsigned DRIFT_W    = 32;
  localparam int unsigned VOL_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_START_PRICE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLATILITY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATHS         = 3'd4;

  // Q.30 constants
  localparam logic [30:0] ONE_Q    = 31'h4000_0000;
  localparam logic [30:0] TWO_LN2  = 31'd1488522236;
  localparam logic [30:0] HALF_PI  = 31'd1686629713;
  localparam logic [29:0] LN2      = 30'd744261118;
  // floor(2^40 / LN2)
  localparam logic [10:0] LN2_RCP  = 11'd1477;
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  // Divider table layout: cosine terms, then sine terms, then exp terms.
  localparam logic [5:0] DIV_SIN_BASE = 6'd10;
  localparam logic [5:0] DIV_EXP_BASE = 6'd20;

  typedef struct packed {
    logic [UNI_W-1:0] uniform_a;
    logic [UNI_W-1:0] uniform_b;
  } item_t;

  typedef struct packed {
    logic [PRICE_W-1:0]        start_price;
    logic signed [DRIFT_W-1:0] drift_per_step;
    logic [VOL_W-1:0]          volatility_per_step;
    logic [STEP_W-1:0]         steps_per_path;
    logic [PATH_W-1:0]         path_count;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EMIT0, ST_NORM, ST_LNSQ, ST_LNM1, ST_LNM2, ST_LNM3, ST_SQRT,
    ST_CA, ST_CX2, ST_TMUL, ST_TRCP, ST_TFIX, ST_ZMUL, ST_VZ, ST_HV, ST_XSUM,
    ST_KMUL, ST_KFIX, ST_PHI, ST_PLO, ST_PSUM, ST_SCALE, ST_EMIT1
  } back_state_t;

  // Divisor of each series term.
  function automatic logic [8:0] div_den(input logic [5:0] code);
    logic [8:0] d;
    unique case (code)
      6'd0:  d = 9'd2;    6'd1:  d = 9'd12;   6'd2:  d = 9'd30;   6'd3:  d = 9'd56;
      6'd4:  d = 9'd90;   6'd5:  d = 9'd132;  6'd6:  d = 9'd182;  6'd7:  d = 9'd240;
      6'd8:  d = 9'd306;  6'd9:  d = 9'd380;
      6'd10: d = 9'd6;    6'd11: d = 9'd20;   6'd12: d = 9'd42;   6'd13: d = 9'd72;
      6'd14: d = 9'd110;  6'd15: d = 9'd156;  6'd16: d = 9'd210;  6'd17: d = 9'd272;
      6'd18: d = 9'd342;  6'd19: d = 9'd420;
      6'd20: d = 9'd1;    6'd21: d = 9'd2;    6'd22: d = 9'd3;    6'd23: d = 9'd4;
      6'd24: d = 9'd5;    6'd25: d = 9'd6;    6'd26: d = 9'd7;    6'd27: d = 9'd8;
      6'd28: d = 9'd9;    6'd29: d = 9'd10;   6'd30: d = 9'd11;   6'd31: d = 9'd12;
      6'd32: d = 9'd13;   6'd33: d = 9'd14;
      default: d = 9'd1;
    endcase
    return d;
  endfunction

  // floor(2^33 / divisor); one correction step after the multiply gives the
  // exact quotient for dividends below 2^33.
  function automatic logic [33:0] div_rcp(input logic [5:0] code);
    logic [33:0] r;
    unique case (code)
      6'd0:  r = 34'd4294967296; 6'd1:  r = 34'd715827882;  6'd2:  r = 34'd286331153;
      6'd3:  r = 34'd153391689;  6'd4:  r = 34'd95443717;   6'd5:  r = 34'd65075262;
      6'd6:  r = 34'd47197442;   6'd7:  r = 34'd35791394;   6'd8:  r = 34'd28071681;
      6'd9:  r = 34'd22605091;
      6'd10: r = 34'd1431655765; 6'd11: r = 34'd429496729;  6'd12: r = 34'd204522252;
      6'd13: r = 34'd119304647;  6'd14: r = 34'd78090314;   6'd15: r = 34'd55063683;
      6'd16: r = 34'd40904450;   6'd17: r = 34'd31580641;   6'd18: r = 34'd25116767;
      6'd19: r = 34'd20452225;
      6'd20: r = 34'd8589934592; 6'd21: r = 34'd4294967296; 6'd22: r = 34'd2863311530;
      6'd23: r = 34'd2147483648; 6'd24: r = 34'd1717986918; 6'd25: r = 34'd1431655765;
      6'd26: r = 34'd1227133513; 6'd27: r = 34'd1073741824; 6'd28: r = 34'd954437176;
      6'd29: r = 34'd858993459;  6'd30: r = 34'd780903144;  6'd31: r = 34'd715827882;
      6'd32: r = 34'd660764199;  6'd33: r = 34'd613566756;
      default: r = 34'd8589934592;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/gpp_ifs.sv
// Valid/ready channel interfaces for the uniform input pair and the price result.
// Depends on gpp_pkg for field widths.
`default_nettype none

interface gpp_in_if import gpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [UNI_W-1:0] uniform_a;
  logic [UNI_W-1:0] uniform_b;
  modport source (output valid, uniform_a, uniform_b, input ready);
  modport sink   (input valid, uniform_a, uniform_b, output ready);
endinterface

interface gpp_out_if import gpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRICE_W-1:0] price;
  logic [STEP_W-1:0]  step_index;
  logic [PATH_W-1:0]  path_index;
  logic               last_of_item;
  logic               path_done;
  logic               run_done;
  modport source (output valid, price, step_index, path_index, last_of_item, path_done,
                  run_done, input ready);
  modport sink   (input valid, price, step_index, path_index, last_of_item, path_done,
                  run_done, output ready);
endinterface

`default_nettype wire

### src/gpp_front.sv
// Front end: accepts uniform pairs, clamps a zero first uniform to one LSB and
// buffers requests in a two-entry queue for the back end. Uses gpp_pkg, gpp_in_if.
`default_nettype none

module gpp_front import gpp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  gpp_in_if.sink   in_ch,
  input  logic     pop,
  output logic     q_valid,
  output item_t    q_item
);

  localparam int unsigned QDEPTH = 2;

  item_t       slot_r [QDEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push, do_pop;
  item_t       push_item;

  assign in_ch.ready = (count_r != 2'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign do_pop      = pop && q_valid;
  assign q_item      = slot_r[rd_ptr_r];

  always_comb begin
    // The log of zero does not exist, so a zero fraction becomes 2^-32.
    push_item.uniform_a = (in_ch.uniform_a == '0) ? UNI_W'(1) : in_ch.uniform_a;
    push_item.uniform_b = in_ch.uniform_b;
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

### src/gpp_back.sv
// Back end: sequential Box-Muller and exponential price update engine with the
// path counters and the result register. Uses gpp_pkg and gpp_out_if.
`default_nettype none

module gpp_back import gpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  item_t     q_item,
  output logic      pop,
  gpp_out_if.source out_ch
);

  back_state_t state_r, state_nxt;

  item_t              item_r;
  logic [31:0]        norm_r;
  logic [4:0]         lz_r;
  logic [30:0]        m_r;
  logic [29:0]        frac_r;
  logic [4:0]         cnt_r;
  logic [35:0]        l_r;
  logic [36:0]        lhi_r;
  logic [60:0]        llo_r;
  logic [63:0]        v_r, r_r;
  logic [1:0]         quad_r;
  logic [30:0]        a_r;
  logic [31:0]        mulb_r;
  logic [31:0]        mag_r;
  logic signed [35:0] sum_r;
  logic               exp_ph_r;
  logic [32:0]        xq_r;
  logic [32:0]        q0_r;
  logic               cneg_r;
  logic [35:0]        zmag_r;
  logic [36:0]        vz_r;
  logic [30:0]        hv_r;
  logic signed [38:0] x_r;
  logic signed [9:0]  k_r;
  logic [51:0]        phi_r, plo_r;
  logic [41:0]        p_r;
  logic [PRICE_W-1:0] price_r;
  logic [STEP_W-1:0]  step_cnt_r;
  logic [PATH_W-1:0]  path_cnt_r;

  logic               out_v_r;
  logic [PRICE_W-1:0] out_price_r;
  logic [STEP_W-1:0]  out_step_r;
  logic [PATH_W-1:0]  out_path_r;
  logic               out_last_r, out_pd_r, out_rd_r;

  // combinational helpers
  logic               can_load, out_load;
  logic [61:0]        sq;
  logic [35:0]        l_calc;
  logic [63:0]        sq_b, sq_rb;
  logic [5:0]         div_code;
  logic [8:0]         den;
  logic [66:0]        rcp_prod;
  logic [41:0]        qd, rem;
  logic [32:0]        q_fix;
  logic signed [35:0] q_s;
  logic [35:0]        cabs;
  logic               trig_neg;
  logic signed [50:0] kprod;
  logic signed [38:0] f0;
  logic [71:0]        p_sum;
  logic [81:0]        wide;
  logic [9:0]         kn;
  logic [41:0]        shr;
  logic [PRICE_W-1:0] newp;
  logic [STEP_W-1:0]  eff_steps, step_inc;
  logic [PATH_W-1:0]  eff_paths;
  logic [PATH_W:0]    path_inc;
  logic               pd, rd;
  logic               last_term;

  assign can_load = !out_v_r || out_ch.ready;
  assign out_load = ((state_r == ST_EMIT0) || (state_r == ST_EMIT1)) && can_load;

  always_comb begin
    if (cfg.steps_per_path == '0) begin
      eff_steps = STEP_W'(1);
    end else if (cfg.steps_per_path > STEP_W'(MAX_STEPS)) begin
      eff_steps = STEP_W'(MAX_STEPS);
    end else begin
      eff_steps = cfg.steps_per_path;
    end
    eff_paths = (cfg.path_count == '0) ? PATH_W'(1) : cfg.path_count;
    step_inc  = step_cnt_r + STEP_W'(1);
    path_inc  = {1'b0, path_cnt_r} + (PATH_W+1)'(1);
    pd        = (step_inc >= eff_steps);
    rd        = pd && (path_inc >= {1'b0, eff_paths});
  end

  always_comb begin
    sq     = 62'(m_r) * 62'(m_r);
    l_calc = {({1'b0, lz_r} + 6'd1), 30'b0} - {6'b0, frac_r};
    sq_b   = 64'd1 << {cnt_r, 1'b0};
    sq_rb  = r_r + sq_b;

    if (exp_ph_r) begin
      div_code = DIV_EXP_BASE + {2'b0, cnt_r[3:0]};
    end else if (quad_r[0]) begin
      div_code = DIV_SIN_BASE + {2'b0, cnt_r[3:0]};
    end else begin
      div_code = {2'b0, cnt_r[3:0]};
    end
    den      = div_den(div_code);
    rcp_prod = 67'(xq_r) * 67'(div_rcp(div_code));
    qd       = 42'(q0_r) * 42'(den);
    rem      = 42'(xq_r) - qd;
    q_fix    = (rem >= 42'(den)) ? q0_r + 33'd1 : q0_r;
    q_s      = signed'({3'b0, q_fix});
    last_term = exp_ph_r ? (cnt_r == 5'd13) : (cnt_r == 5'd9);

    cabs     = sum_r[35] ? 36'(-sum_r) : 36'(sum_r);
    // Second and third quadrants flip the sign of the series value.
    trig_neg = (quad_r == 2'd1) || (quad_r == 2'd2);

    kprod = 51'(x_r) * 51'(signed'({1'b0, LN2_RCP}));
    f0    = x_r - 39'(k_r) * signed'({9'b0, LN2});

    p_sum = {phi_r, 20'b0} + 72'(plo_r);

    wide = 82'(p_r) << k_r[5:0];
    kn   = 10'(-k_r);
    shr  = p_r >> kn[5:0];
    if (price_r == '0) begin
      newp = '0;
    end else if (!k_r[9]) begin
      if (k_r >= 10'sd40) begin
        newp = PRICE_MAX;
      end else begin
        newp = (|wide[81:40]) ? PRICE_MAX : wide[39:0];
      end
    end else if (kn >= 10'd63) begin
      newp = '0;
    end else begin
      newp = (|shr[41:40]) ? PRICE_MAX : shr[39:0];
    end
  end

  // Next state and queue pop.
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          state_nxt = (step_cnt_r == '0) ? ST_EMIT0 : ST_NORM;
        end
      end
      ST_EMIT0: if (can_load) state_nxt = ST_NORM;
      ST_NORM:  if (norm_r[31]) state_nxt = ST_LNSQ;
      ST_LNSQ:  if (cnt_r == 5'd30) state_nxt = ST_LNM1;
      ST_LNM1:  state_nxt = ST_LNM2;
      ST_LNM2:  state_nxt = ST_LNM3;
      ST_LNM3:  state_nxt = ST_SQRT;
      ST_SQRT:  if (cnt_r == 5'd0) state_nxt = ST_CA;
      ST_CA:    state_nxt = ST_CX2;
      ST_CX2:   state_nxt = ST_TMUL;
      ST_TMUL:  state_nxt = ST_TRCP;
      ST_TRCP:  state_nxt = ST_TFIX;
      ST_TFIX: begin
        if (!last_term) begin
          state_nxt = ST_TMUL;
        end else begin
          state_nxt = exp_ph_r ? ST_PHI : ST_ZMUL;
        end
      end
      ST_ZMUL:  state_nxt = ST_VZ;
      ST_VZ:    state_nxt = ST_HV;
      ST_HV:    state_nxt = ST_XSUM;
      ST_XSUM:  state_nxt = ST_KMUL;
      ST_KMUL:  state_nxt = ST_KFIX;
      ST_KFIX:  state_nxt = ST_TMUL;
      ST_PHI:   state_nxt = ST_PLO;
      ST_PLO:   state_nxt = ST_PSUM;
      ST_PSUM:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_EMIT1;
      ST_EMIT1: if (can_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_cnt_r <= '0;
      path_cnt_r <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (out_load && (state_r == ST_EMIT1)) begin
        if (pd) begin
          step_cnt_r <= '0;
          path_cnt_r <= rd ? '0 : path_inc[PATH_W-1:0];
        end else begin
          step_cnt_r <= step_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_price_r <= price_r;
      out_path_r  <= path_cnt_r;
      if (state_r == ST_EMIT0) begin
        out_step_r <= '0;
        out_last_r <= 1'b0;
        out_pd_r   <= 1'b0;
        out_rd_r   <= 1'b0;
      end else begin
        out_step_r <= step_inc;
        out_last_r <= 1'b1;
        out_pd_r   <= pd;
        out_rd_r   <= rd;
      end
    end
  end

  // Datapath registers, one unit step per cycle; the emit states wait while the result register is full.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          item_r <= q_item;
          norm_r <= q_item.uniform_a;
          lz_r   <= '0;
          if (step_cnt_r == '0) price_r <= cfg.start_price;
        end
      end
      ST_NORM: begin
        if (norm_r[31]) begin
          m_r    <= norm_r[31:1];
          frac_r <= '0;
          cnt_r  <= 5'd1;
        end else begin
          norm_r <= norm_r << 1;
          lz_r   <= lz_r + 5'd1;
        end
      end
      ST_LNSQ: begin
        // Repeated squaring yields one fraction bit of log2 per cycle.
        if (sq[61]) begin
          m_r <= sq[61:31];
          frac_r[5'd30 - cnt_r] <= 1'b1;
        end else begin
          m_r <= sq[60:30];
        end
        cnt_r <= cnt_r + 5'd1;
      end
      ST_LNM1: l_r <= l_calc;
      ST_LNM2: begin
        lhi_r <= 37'(l_r[35:30]) * 37'(TWO_LN2);
        llo_r <= 61'(l_r[29:0]) * 61'(TWO_LN2);
      end
      ST_LNM3: begin
        v_r   <= {2'b0, (36'(lhi_r) + 36'(llo_r[60:30])), 26'b0};
        r_r   <= '0;
        cnt_r <= 5'd31;
      end
      ST_SQRT: begin
        if (v_r >= sq_rb) begin
          v_r <= v_r - sq_rb;
          r_r <= (r_r >> 1) + sq_b;
        end else begin
          r_r <= r_r >> 1;
        end
        cnt_r <= cnt_r - 5'd1;
      end
      ST_CA: begin
        a_r    <= 31'((61'(item_r.uniform_b[29:0]) * 61'(HALF_PI)) >> 30);
        quad_r <= item_r.uniform_b[31:30];
      end
      ST_CX2: begin
        mulb_r   <= 32'((62'(a_r) * 62'(a_r)) >> 30);
        mag_r    <= quad_r[0] ? {1'b0, a_r} : {1'b0, ONE_Q};
        sum_r    <= quad_r[0] ? signed'({5'b0, a_r}) : signed'({5'b0, ONE_Q});
        exp_ph_r <= 1'b0;
        cnt_r    <= '0;
      end
      ST_TMUL: xq_r <= 33'((64'(mag_r) * 64'(mulb_r)) >> 30);
      ST_TRCP: q0_r <= rcp_prod[65:33];
      ST_TFIX: begin
        mag_r <= q_fix[31:0];
        if (exp_ph_r || cnt_r[0]) begin
          sum_r <= sum_r + q_s;
        end else begin
          sum_r <= sum_r - q_s;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      ST_ZMUL: begin
        cneg_r <= trig_neg ? (!sum_r[35] && (sum_r != '0)) : sum_r[35];
        zmag_r <= 36'((64'(r_r[30:0]) * 64'(cabs[31:0])) >> 28);
      end
      ST_VZ: vz_r <= 37'((67'(cfg.volatility_per_step) * 67'(zmag_r)) >> 30);
      ST_HV: hv_r <= 31'((62'(cfg.volatility_per_step) * 62'(cfg.volatility_per_step)) >> 31);
      ST_XSUM: begin
        if (cneg_r) begin
          x_r <= 39'(cfg.drift_per_step) - signed'({8'b0, hv_r}) - signed'({2'b0, vz_r});
        end else begin
          x_r <= 39'(cfg.drift_per_step) - signed'({8'b0, hv_r}) + signed'({2'b0, vz_r});
        end
      end
      ST_KMUL: k_r <= kprod[49:40];
      ST_KFIX: begin
        // The reciprocal estimate is off by at most one in either direction.
        if (f0 < 0) begin
          k_r    <= k_r - 10'sd1;
          mulb_r <= 32'(f0 + signed'({9'b0, LN2}));
        end else if (f0 >= signed'({9'b0, LN2})) begin
          k_r    <= k_r + 10'sd1;
          mulb_r <= 32'(f0 - signed'({9'b0, LN2}));
        end else begin
          mulb_r <= 32'(f0);
        end
        mag_r    <= {1'b0, ONE_Q};
        sum_r    <= signed'({5'b0, ONE_Q});
        exp_ph_r <= 1'b1;
        cnt_r    <= '0;
      end
      ST_PHI:   phi_r <= 52'(price_r[39:20]) * 52'(sum_r[31:0]);
      ST_PLO:   plo_r <= 52'(price_r[19:0]) * 52'(sum_r[31:0]);
      ST_PSUM:  p_r   <= p_sum[71:30];
      ST_SCALE: price_r <= newp;
      ST_EMIT0, ST_EMIT1: begin
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.price        = out_price_r;
  assign out_ch.step_index   = out_step_r;
  assign out_ch.path_index   = out_path_r;
  assign out_ch.last_of_item = out_last_r;
  assign out_ch.path_done    = out_pd_r;
  assign out_ch.run_done     = out_rd_r;

  a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_last_r |-> (out_step_r == '0) && !out_pd_r && !out_rd_r)
    else $error("initial price result carries step or done flags");

  a_run_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_rd_r |-> out_pd_r)
    else $error("run end without path end");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_cnt_r < STEP_W'(MAX_STEPS))
    else $error("step counter beyond path limit");

endmodule

`default_nettype wire

### src/gbm_price_path_step.sv
// GBM price path step, top level: configuration registers, front end and back end.
// Uses gpp_pkg, gpp_in_if, gpp_out_if, gpp_front and gpp_back.
//
// Usage: each request on in_ch carries two uniform fractions (Q0.32). The block
// turns them into a normal deviate by Box-Muller and moves the kept price one
// time step along a geometric Brownian motion. The first request of a path
// first returns the initial price (step 0), then the new price; every other
// request returns one price. Results leave on out_ch with step, path and done
// flags; last_of_item marks the final result of a request.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while idle, as the block itself does not enforce it. The time a
// request spends in the back end varies with the leading-zero scan of the first
// uniform and is longer when it starts a path. The engine runs one unit step
// per cycle through the log squaring loop, the square root recurrence, the
// cosine series and the exponential series, and finishes one request before it
// takes the next. A two-entry queue takes requests while the engine is busy,
// and a result register holds a result while the receiver stalls, so the
// engine only waits when the result register is still full.
// Reset (synchronous, rst_n low) restores the register defaults and starts at
// step 0 of path 0.
`default_nettype none

module gbm_price_path_step import gpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gpp_in_if.sink                in_ch,
  gpp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  logic  q_valid, pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_price         <= PRICE_W'(6553600);
      cfg_r.drift_per_step      <= DRIFT_W'(53687091);
      cfg_r.volatility_per_step <= VOL_W'(214748365);
      cfg_r.steps_per_path      <= STEP_W'(10);
      cfg_r.path_count          <= PATH_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_PRICE:   cfg_r.start_price         <= cfg_wdata[PRICE_W-1:0];
        CFG_DRIFT:         cfg_r.drift_per_step      <= signed'(cfg_wdata[DRIFT_W-1:0]);
        CFG_VOLATILITY:    cfg_r.volatility_per_step <= cfg_wdata[VOL_W-1:0];
        CFG_STEPS:         cfg_r.steps_per_path      <= cfg_wdata[STEP_W-1:0];
        CFG_PATHS:         cfg_r.path_count          <= cfg_wdata[PATH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gpp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .pop     (pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  gpp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
